// ===== sv/i2cr_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cr_pkg
// Types and phase constants shared by the I2C register-read sequencer.
// ----------------------------------------------------------------------------
package i2cr_pkg;

    localparam int unsigned PHASE_W = 7;

    localparam logic [PHASE_W-1:0] PH_IDLE       = 7'd0;
    localparam logic [PHASE_W-1:0] PH_START_A    = 7'd1;
    localparam logic [PHASE_W-1:0] PH_START_B    = 7'd2;
    localparam logic [PHASE_W-1:0] PH_ADDRW_0    = 7'd3;
    localparam logic [PHASE_W-1:0] PH_ADDRW_N    = 7'd18;
    localparam logic [PHASE_W-1:0] PH_ACK1_LO    = 7'd19;
    localparam logic [PHASE_W-1:0] PH_ACK1_HI    = 7'd20;
    localparam logic [PHASE_W-1:0] PH_CTRL_0     = 7'd21;
    localparam logic [PHASE_W-1:0] PH_CTRL_N     = 7'd36;
    localparam logic [PHASE_W-1:0] PH_ACK2_LO    = 7'd37;
    localparam logic [PHASE_W-1:0] PH_ACK2_HI    = 7'd38;
    localparam logic [PHASE_W-1:0] PH_RS_A       = 7'd39;
    localparam logic [PHASE_W-1:0] PH_RS_B       = 7'd40;
    localparam logic [PHASE_W-1:0] PH_RS_C       = 7'd41;
    localparam logic [PHASE_W-1:0] PH_ADDRR_0    = 7'd42;
    localparam logic [PHASE_W-1:0] PH_ADDRR_N    = 7'd57;
    localparam logic [PHASE_W-1:0] PH_ACK3_LO    = 7'd58;
    localparam logic [PHASE_W-1:0] PH_ACK3_HI    = 7'd59;
    localparam logic [PHASE_W-1:0] PH_READ_0     = 7'd60;
    localparam logic [PHASE_W-1:0] PH_READ_N     = 7'd75;
    localparam logic [PHASE_W-1:0] PH_NACK_LO    = 7'd76;
    localparam logic [PHASE_W-1:0] PH_NACK_HI    = 7'd77;
    localparam logic [PHASE_W-1:0] PH_STOP_A     = 7'd78;
    localparam logic [PHASE_W-1:0] PH_STOP_B     = 7'd79;
    localparam logic [PHASE_W-1:0] PH_LAST       = 7'd80;

    localparam logic [6:0] DEV_ADDR_RESET = 7'd72;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [7:0]         tx_shift;
        logic [7:0]         rx_shift;
        logic [7:0]         ctrl_latched;
        logic               nack_flag;
        logic               scl_drive;
        logic               sda_drive;
    } seq_state_t;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic busy_res;
        logic done_res;
        logic [7:0] read_byte;
        logic addr_nack;
    } seq_result_t;

endpackage

// ===== sv/i2cr_phase.sv =====
// ----------------------------------------------------------------------------
// i2cr_phase
// Next-state and result logic for one bus phase of the read sequencer.
// ----------------------------------------------------------------------------
module i2cr_phase (
    input  i2cr_pkg::seq_state_t  cur,
    input  logic [6:0]            device_address,
    input  logic                  action,
    input  logic [7:0]            ctrl_byte,
    input  logic                  sda_in,
    output i2cr_pkg::seq_state_t  nxt,
    output i2cr_pkg::seq_result_t res
);
    import i2cr_pkg::*;

    logic [PHASE_W-1:0] p;
    logic [PHASE_W-1:0] off_full;
    logic [3:0]         off;
    logic [7:0]         load;
    logic [7:0]         tx_cur;
    logic [7:0]         rx_cur;
    logic               busy;
    logic               done;

    always_comb
    begin
        nxt      = cur;
        busy     = 1'b0;
        done     = 1'b0;
        p        = cur.phase;
        off_full = '0;
        load     = '0;
        tx_cur   = cur.tx_shift;
        rx_cur   = cur.rx_shift;

        if (p == PH_IDLE && action)
        begin
            nxt.ctrl_latched = ctrl_byte;
            p = PH_START_A;
        end

        // segment base for byte phases
        case (p) inside
            [PH_ADDRW_0:PH_ADDRW_N]:
            begin
                off_full = p - PH_ADDRW_0;
                load     = {device_address, 1'b0};
            end
            [PH_CTRL_0:PH_CTRL_N]:
            begin
                off_full = p - PH_CTRL_0;
                load     = nxt.ctrl_latched;
            end
            [PH_ADDRR_0:PH_ADDRR_N]:
            begin
                off_full = p - PH_ADDRR_0;
                load     = {device_address, 1'b1};
            end
            [PH_READ_0:PH_READ_N]:
            begin
                off_full = p - PH_READ_0;
            end
            default:
            begin
                off_full = '0;
            end
        endcase
        off = off_full[3:0];

        if (off == 4'd0)
        begin
            tx_cur = load;
            rx_cur = '0;
        end

        if (p != PH_IDLE)
        begin
            busy = 1'b1;
            case (p) inside
                PH_START_A:
                begin
                    nxt.scl_drive = 1'b1;
                    nxt.sda_drive = 1'b1;
                end
                PH_START_B:
                begin
                    nxt.scl_drive = 1'b1;
                    nxt.sda_drive = 1'b0;
                end
                [PH_ADDRW_0:PH_ADDRW_N], [PH_CTRL_0:PH_CTRL_N], [PH_ADDRR_0:PH_ADDRR_N]:
                begin
                    if (!off[0])
                    begin
                        nxt.scl_drive = 1'b0;
                        nxt.sda_drive = tx_cur[7];
                        nxt.tx_shift  = tx_cur;
                    end
                    else
                    begin
                        nxt.scl_drive = 1'b1;
                        nxt.tx_shift  = {tx_cur[6:0], 1'b0};
                    end
                end
                PH_ACK1_LO, PH_ACK2_LO, PH_ACK3_LO, PH_RS_A, PH_NACK_LO:
                begin
                    nxt.scl_drive = 1'b0;
                    nxt.sda_drive = 1'b1;
                end
                PH_ACK1_HI, PH_ACK3_HI:
                begin
                    nxt.scl_drive = 1'b1;
                    nxt.sda_drive = 1'b1;
                    nxt.nack_flag = sda_in;
                end
                PH_ACK2_HI, PH_RS_B, PH_NACK_HI:
                begin
                    nxt.scl_drive = 1'b1;
                    nxt.sda_drive = 1'b1;
                end
                PH_RS_C:
                begin
                    nxt.scl_drive = 1'b1;
                    nxt.sda_drive = 1'b0;
                end
                [PH_READ_0:PH_READ_N]:
                begin
                    nxt.sda_drive = 1'b1;
                    if (!off[0])
                    begin
                        nxt.scl_drive = 1'b0;
                        nxt.rx_shift  = rx_cur;
                    end
                    else
                    begin
                        nxt.scl_drive = 1'b1;
                        nxt.rx_shift  = {rx_cur[6:0], sda_in};
                    end
                end
                PH_STOP_A:
                begin
                    nxt.scl_drive = 1'b0;
                    nxt.sda_drive = 1'b0;
                end
                PH_STOP_B:
                begin
                    nxt.scl_drive = 1'b1;
                    nxt.sda_drive = 1'b0;
                end
                default:
                begin
                    nxt.scl_drive = 1'b1;
                    nxt.sda_drive = 1'b1;
                end
            endcase

            if (p >= PH_LAST)
            begin
                done      = 1'b1;
                nxt.phase = PH_IDLE;
            end
            else
            begin
                nxt.phase = p + 7'd1;
            end
        end

        res.scl_level = nxt.scl_drive;
        res.sda_level = nxt.sda_drive;
        res.busy_res  = busy;
        res.done_res  = done;
        res.read_byte = nxt.rx_shift;
        res.addr_nack = nxt.nack_flag;
    end

endmodule

// ===== sv/i2c_master_adc_read.sv =====
// ----------------------------------------------------------------------------
// i2c_master_adc_read
// I2C master sequencer for one register-read transaction, one bus phase per tick.
// ----------------------------------------------------------------------------
// Each accepted input transaction is one bus tick and produces exactly one
// registered output transaction; a tick is taken every cycle as long as
// the output side keeps up. A tick with tuser high while idle starts a read:
// start, address+W, control byte, repeated start, address+R, eight data bits,
// NACK, stop, 80 ticks in all. tlast marks the tick on which stop completes;
// read_byte is then valid and addr_nack reports the read-address acknowledge.
// The device address register (reset 72) should only be written while idle.
module i2c_master_adc_read (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,      // device_address
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,        // ctrl_byte[7:0], sda_in[8], zero pad
    input  logic        s_tuser,        // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,        // scl_level[0], sda_level[1], busy_res[2],
                                        // read_byte[10:3], addr_nack[11], zero pad
    output logic        m_tlast         // done_res
);
    import i2cr_pkg::*;

    seq_state_t  state_reg;
    seq_state_t  state_next;
    seq_result_t res_next;
    logic [6:0]  dev_addr_reg;
    logic        m_valid_reg;
    logic [15:0] m_tdata_reg;
    logic        m_tlast_reg;
    logic        accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    i2cr_phase u_phase (
        .cur            (state_reg),
        .device_address (dev_addr_reg),
        .action         (s_tuser),
        .ctrl_byte      (s_tdata[7:0]),
        .sda_in         (s_tdata[8]),
        .nxt            (state_next),
        .res            (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg          <= DEV_ADDR_RESET;
            state_reg.phase       <= PH_IDLE;
            state_reg.tx_shift    <= '0;
            state_reg.rx_shift    <= '0;
            state_reg.ctrl_latched <= '0;
            state_reg.nack_flag   <= 1'b0;
            state_reg.scl_drive   <= 1'b1;
            state_reg.sda_drive   <= 1'b1;
            m_valid_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dev_addr_reg <= cfg_wdata;
            end
            if (accept)
            begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {4'd0, res_next.addr_nack, res_next.read_byte,
                            res_next.busy_res, res_next.sda_level, res_next.scl_level};
            m_tlast_reg <= res_next.done_res;
        end
    end

endmodule

// ===== tb/tb_i2c_master_adc_read.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_master_adc_read
// Self-checking bench for the I2C register-read sequencer.
// ----------------------------------------------------------------------------
// Every input transaction is one bus tick and is predicted by an in-bench
// model of the sequencer. Directed tests cover idle ticks, the reset address,
// address extremes, acked and nacked transfers and requests while busy. The
// random test drives complete read transfers with random control bytes,
// read data and acknowledge levels, mixed with noise ticks, and rewrites the
// device address between transfers. Input gaps and output stalls are random.
// ----------------------------------------------------------------------------
module tb_i2c_master_adc_read;
    import i2cr_pkg::*;

    localparam int RANDOM_TICKS = 1850;
    localparam int MAX_REPORTS  = 100;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // bench copy of the sequencer state
    logic [PHASE_W-1:0] model_phase    = PH_IDLE;
    logic [7:0]         model_tx_shift = '0;
    logic [7:0]         model_rx_shift = '0;
    logic [7:0]         model_ctrl     = '0;
    logic               model_nack     = 1'b0;
    logic               model_scl      = 1'b1;
    logic               model_sda      = 1'b1;
    logic [6:0]         model_dev_addr = DEV_ADDR_RESET;

    seq_result_t predicted_ticks[$];
    seq_result_t want;
    int          errors      = 0;
    int          ticks_sent  = 0;
    int          burst_left  = 0;
    bit          tx_gap_on   = 1'b1;
    bit          rx_stall_on = 1'b1;
    logic [31:0] ready_pattern = '0;
    int          pattern_age   = 0;

    i2c_master_adc_read dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic void shift_out_bit(input int unsigned off, input logic [7:0] load);
        if (off == 0)
            model_tx_shift = load;
        if (off % 2 == 0)
        begin
            model_scl = 1'b0;
            model_sda = model_tx_shift[7];
        end
        else
        begin
            model_scl = 1'b1;
            model_tx_shift = model_tx_shift << 1;
        end
    endfunction

    function automatic seq_result_t predict_bus_phase(input logic action,
                                                      input logic [7:0] ctrl,
                                                      input logic sda_in);
        seq_result_t        r;
        logic [7:0]         addr_w;
        logic [PHASE_W-1:0] p;
        r = '0;
        addr_w = {model_dev_addr, 1'b0};
        if (model_phase == PH_IDLE && action)
        begin
            model_ctrl  = ctrl;
            model_phase = PH_START_A;
        end
        if (model_phase != PH_IDLE)
        begin
            p = model_phase;
            r.busy_res = 1'b1;
            if (p == PH_START_A)
                {model_scl, model_sda} = 2'b11;
            else if (p == PH_START_B)
                {model_scl, model_sda} = 2'b10;
            else if (p <= PH_ADDRW_N)
                shift_out_bit(p - PH_ADDRW_0, addr_w);
            else if (p == PH_ACK1_LO || p == PH_ACK2_LO || p == PH_ACK3_LO)
                {model_scl, model_sda} = 2'b01;
            else if (p == PH_ACK1_HI || p == PH_ACK3_HI)
            begin
                {model_scl, model_sda} = 2'b11;
                model_nack = sda_in;
            end
            else if (p <= PH_CTRL_N)
                shift_out_bit(p - PH_CTRL_0, model_ctrl);
            else if (p == PH_ACK2_HI)
                {model_scl, model_sda} = 2'b11;
            else if (p == PH_RS_A)
                {model_scl, model_sda} = 2'b01;
            else if (p == PH_RS_B)
                {model_scl, model_sda} = 2'b11;
            else if (p == PH_RS_C)
                {model_scl, model_sda} = 2'b10;
            else if (p <= PH_ADDRR_N)
                shift_out_bit(p - PH_ADDRR_0, addr_w | 8'h01);
            else if (p <= PH_READ_N)
            begin
                model_sda = 1'b1;
                if (p == PH_READ_0)
                    model_rx_shift = '0;
                if (p[0] == PH_READ_0[0])
                    model_scl = 1'b0;
                else
                begin
                    model_scl = 1'b1;
                    model_rx_shift = {model_rx_shift[6:0], sda_in};
                end
            end
            else if (p == PH_NACK_LO)
                {model_scl, model_sda} = 2'b01;
            else if (p == PH_NACK_HI)
                {model_scl, model_sda} = 2'b11;
            else if (p == PH_STOP_A)
                {model_scl, model_sda} = 2'b00;
            else if (p == PH_STOP_B)
                {model_scl, model_sda} = 2'b10;
            else
                {model_scl, model_sda} = 2'b11;
            if (p >= PH_LAST)
            begin
                r.done_res  = 1'b1;
                model_phase = PH_IDLE;
            end
            else
                model_phase = p + 7'd1;
        end
        r.scl_level = model_scl;
        r.sda_level = model_sda;
        r.read_byte = model_rx_shift;
        r.addr_nack = model_nack;
        return r;
    endfunction

    // sender: bursts of random length separated by random gaps
    task automatic send_tick(input logic action, input logic [7:0] ctrl, input logic sda_in);
        if (tx_gap_on && burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {7'b0, sda_in, ctrl};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted_ticks.push_back(predict_bus_phase(action, ctrl, sda_in));
        burst_left--;
        ticks_sent++;
    endtask

    task automatic wait_for_outputs();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (predicted_ticks.size() != 0)
            @(posedge clk);
    endtask

    task automatic finish_transaction();
        while (model_phase != PH_IDLE)
            send_tick(1'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic write_dev_addr(input logic [6:0] addr);
        finish_transaction();
        wait_for_outputs();
        cfg_we    <= 1'b1;
        cfg_wdata <= addr;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_dev_addr = addr;
    endtask

    task automatic send_noise(input int count);
        repeat (count)
            send_tick($urandom_range(0, 9) == 0, 8'($urandom), 1'($urandom));
    endtask

    // one complete read transfer; the target answers with the given acknowledge levels and returns rx_data
    task automatic run_read(input logic [7:0] ctrl, input logic [7:0] rx_data,
                            input logic ack_w, input logic ack_c, input logic ack_r,
                            input logic poke_busy);
        logic [PHASE_W-1:0] p;
        logic               sda_in;
        finish_transaction();
        send_tick(1'b1, ctrl, 1'($urandom));
        while (model_phase != PH_IDLE)
        begin
            p = model_phase;
            sda_in = 1'($urandom);
            if (p == PH_ACK1_HI)
                sda_in = ack_w;
            else if (p == PH_ACK2_HI)
                sda_in = ack_c;
            else if (p == PH_ACK3_HI)
                sda_in = ack_r;
            else if (p >= PH_READ_0 && p <= PH_READ_N && p[0] != PH_READ_0[0])
                sda_in = rx_data[7 - (p - PH_READ_0) / 2];
            send_tick(poke_busy && $urandom_range(0, 3) == 0, 8'($urandom), sda_in);
        end
    endtask

    task automatic test_idle_ticks();
        send_tick(1'b0, 8'h00, 1'b0);
        send_tick(1'b0, 8'hFF, 1'b1);
        send_tick(1'b0, 8'h5A, 1'b0);
        send_tick(1'b0, 8'hA5, 1'b1);
    endtask

    task automatic test_default_address_read();
        run_read(8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
        run_read(8'hFF, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
        run_read(8'h3C, 8'hC3, 1'b0, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_address_extremes();
        write_dev_addr(7'd0);
        run_read(8'hA5, 8'h5A, 1'b0, 1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 8'h00, 1'b1);
        send_tick(1'b0, 8'hFF, 1'b0);
        write_dev_addr(7'd127);
        run_read(8'h5A, 8'hA5, 1'b1, 1'b0, 1'b1, 1'b0);
        write_dev_addr(DEV_ADDR_RESET);
        run_read(8'h81, 8'h7E, 1'b0, 1'b0, 1'b0, 1'b1);
    endtask

    task automatic test_random_reads();
        int         txn;
        logic [6:0] addr;
        txn = 0;
        while (ticks_sent < RANDOM_TICKS)
        begin
            tx_gap_on   = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            if (txn % 5 == 4)
            begin
                case ($urandom_range(0, 3))
                    0:       addr = 7'd0;
                    1:       addr = 7'd127;
                    default: addr = 7'($urandom);
                endcase
                write_dev_addr(addr);
            end
            if ($urandom_range(0, 4) == 0)
                send_noise($urandom_range(1, 12));
            run_read(8'($urandom), 8'($urandom), $urandom_range(0, 3) == 0,
                     1'($urandom), $urandom_range(0, 3) == 0, 1'($urandom));
            if ($urandom_range(0, 9) == 0)
                wait_for_outputs();
            txn++;
        end
    endtask

    // receiver: stalls follow a rotating random pattern
    always @(posedge clk)
    begin
        if (pattern_age == 0)
            ready_pattern = $urandom | 32'h0000_0101;
        m_tready <= !rx_stall_on || ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
        pattern_age = (pattern_age + 1) % 32;
    end

    task automatic compare_field(input string fname, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
        if (want_v !== got_v)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h actual %h",
                         $time, fname, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_ticks.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected transaction, expected none actual tdata %h tlast %b",
                             $time, m_tdata, m_tlast);
            end
            else
            begin
                want = predicted_ticks.pop_front();
                compare_field("scl_level", want.scl_level, m_tdata[0]);
                compare_field("sda_level", want.sda_level, m_tdata[1]);
                compare_field("busy_res",  want.busy_res,  m_tdata[2]);
                compare_field("read_byte", want.read_byte, m_tdata[10:3]);
                compare_field("addr_nack", want.addr_nack, m_tdata[11]);
                compare_field("tdata pad", 8'h00,          m_tdata[15:12]);
                compare_field("done_res",  want.done_res,  m_tlast);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_ticks();
        test_default_address_read();
        test_address_extremes();
        test_random_reads();
        finish_transaction();
        wait_for_outputs();
        repeat (10) @(posedge clk);
        if (errors == 0 && predicted_ticks.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
